// File: hw/rtl/etf_pkg.sv
package etf_pkg;
	localparam int WINDOW_SIZE_DEF = 512;
	localparam int FRAC_BITS_DEF = 28;
	localparam int PIX_W = 9;
	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONST_RE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CONST_IM = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

	typedef struct packed {
		logic signed [31:0] zx;
		logic signed [31:0] zy;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
	} etf_job_t;

	typedef enum logic [2:0] {
		MAP_IDLE,
		MAP_MUL,
		MAP_ADD,
		MAP_PUSH
	} etf_map_state_t;

	typedef enum logic [2:0] {
		IT_IDLE,
		IT_CHECK,
		IT_MUL,
		IT_SUM,
		IT_DONE
	} etf_it_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction
endpackage

// File: hw/rtl/etf_front.sv
module etf_front #(
	parameter int WINDOW_SIZE = etf_pkg::WINDOW_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [etf_pkg::PIX_W-1:0] pixel_x,
	input  logic [etf_pkg::PIX_W-1:0] pixel_y,
	input  logic mode,
	input  logic signed [31:0] view_center_re,
	input  logic signed [31:0] view_center_im,
	input  logic [30:0] view_radius,
	input  logic signed [31:0] const_re,
	input  logic signed [31:0] const_im,
	input  logic q_full,
	output logic q_push,
	output etf_pkg::etf_job_t q_job,
	output logic busy_front
);
	import etf_pkg::*;
	localparam int SH = $clog2(WINDOW_SIZE);

	etf_map_state_t state_q, state_d;
	logic [PIX_W-1:0] px_q, py_q;
	logic [40:0] spx_q, spy_q;
	logic signed [31:0] pr_q, pi_q;
	logic [40:0] div_x, div_y;
	logic signed [43:0] sum_x, sum_y;

	// the window is a power of two, so the divide is a shift
	assign div_x = spx_q >> SH;
	assign div_y = spy_q >> SH;
	assign sum_x = signed'({3'b0, div_x}) - signed'({13'b0, view_radius})
		+ 44'(view_center_re);
	assign sum_y = signed'({3'b0, div_y}) - signed'({13'b0, view_radius})
		+ 44'(view_center_im);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MAP_IDLE: if (start) state_d = MAP_MUL;
			MAP_MUL: state_d = MAP_ADD;
			MAP_ADD: state_d = MAP_PUSH;
			MAP_PUSH: if (!q_full) state_d = MAP_IDLE;
			default: state_d = MAP_IDLE;
		endcase
	end

	always_comb begin
		busy_front = (state_q != MAP_IDLE);
		q_push = (state_q == MAP_PUSH) && !q_full;
		if (mode) begin
			q_job.zx = pr_q;
			q_job.zy = pi_q;
			q_job.cx = const_re;
			q_job.cy = const_im;
		end else begin
			q_job.zx = '0;
			q_job.zy = '0;
			q_job.cx = pr_q;
			q_job.cy = pi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= MAP_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == MAP_IDLE && start) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (state_q == MAP_MUL) begin
			spx_q <= {32'd0, px_q} * {9'd0, view_radius, 1'b0};
			spy_q <= {32'd0, py_q} * {9'd0, view_radius, 1'b0};
		end
		if (state_q == MAP_ADD) begin
			pr_q <= (sum_x > 44'sd2147483647) ? 32'sh7FFFFFFF :
				((sum_x < -44'sd2147483648) ? 32'sh80000000 : sum_x[31:0]);
			pi_q <= (sum_y > 44'sd2147483647) ? 32'sh7FFFFFFF :
				((sum_y < -44'sd2147483648) ? 32'sh80000000 : sum_y[31:0]);
		end
	end
endmodule

// File: hw/rtl/etf_queue.sv
module etf_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  etf_pkg::etf_job_t push_job,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output etf_pkg::etf_job_t head
);
	import etf_pkg::*;
	etf_job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end
endmodule

// File: hw/rtl/etf_back.sv
module etf_back #(
	parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  etf_pkg::etf_job_t job,
	input  logic [etf_pkg::CNT_W-1:0] max_iter,
	output logic job_pop,
	output logic done,
	output logic [etf_pkg::CNT_W-1:0] iterations,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	import etf_pkg::*;
	localparam logic signed [63:0] START64 = -(64'sd2 <<< FRAC_BITS);
	localparam logic signed [31:0] START = (START64 < -64'sd2147483648) ?
		32'sh80000000 : START64[31:0];
	localparam bit NO_ESC = (2 * FRAC_BITS + 2 >= 64);
	localparam logic [63:0] LIMIT = NO_ESC ? 64'd0 : (64'd4 << (2 * FRAC_BITS));

	etf_it_state_t state_q, state_d;
	logic signed [31:0] zx_q, zy_q, cx_q, cy_q, px_q, py_q;
	logic [CNT_W:0] n_q;
	logic signed [63:0] xx_s1, yy_s1, xy_s1;
	logic [CNT_W-1:0] res_q;
	logic over_limit, repeat_z, esc;
	logic [63:0] mag;
	logic signed [63:0] dre, dim;
	logic signed [63:0] fre, fim;

	assign mag = 64'(xx_s1) + 64'(yy_s1);
	assign over_limit = n_q > {1'b0, max_iter};
	assign repeat_z = (zx_q == px_q) && (zy_q == py_q);
	assign esc = !NO_ESC && (mag > LIMIT);
	assign dre = xx_s1 - yy_s1;
	assign fre = dre >>> FRAC_BITS;
	assign fim = xy_s1 >>> (FRAC_BITS - 1);
	assign dim = fim + 64'(cy_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			IT_IDLE: if (job_valid) state_d = IT_MUL;
			IT_MUL: state_d = IT_CHECK;
			IT_CHECK: state_d = (over_limit || repeat_z || esc) ? IT_DONE : IT_SUM;
			IT_SUM: state_d = IT_MUL;
			IT_DONE: state_d = IT_IDLE;
			default: state_d = IT_IDLE;
		endcase
	end

	always_comb begin
		job_pop = (state_q == IT_IDLE) && job_valid;
		done = state_q == IT_DONE;
		iterations = done ? res_q : '0;
		red = done ? 8'((res_q * 5) >> 1) : '0;
		green = done ? 8'((res_q * 9) >> 1) : '0;
		blue = done ? 8'(res_q * 7) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= IT_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			IT_IDLE: begin
				zx_q <= job.zx;
				zy_q <= job.zy;
				cx_q <= job.cx;
				cy_q <= job.cy;
				px_q <= START;
				py_q <= START;
				n_q <= '0;
			end
			IT_MUL: begin
				xx_s1 <= 64'(zx_q) * 64'(zx_q);
				yy_s1 <= 64'(zy_q) * 64'(zy_q);
				xy_s1 <= 64'(zx_q) * 64'(zy_q);
			end
			IT_CHECK: begin
				if (over_limit || repeat_z) res_q <= '0;
				else res_q <= n_q[CNT_W-1:0];
			end
			IT_SUM: begin
				px_q <= zx_q;
				py_q <= zy_q;
				zx_q <= sat32(36'(fre + 64'(cx_q) > 64'sd2147483647 ? 64'sd2147483648 :
					(fre + 64'(cx_q) < -64'sd2147483648 ? -64'sd2147483649 : fre + 64'(cx_q))));
				zy_q <= sat32(36'(dim > 64'sd2147483647 ? 64'sd2147483648 :
					(dim < -64'sd2147483648 ? -64'sd2147483649 : dim)));
				n_q <= n_q + 1'b1;
			end
			IT_DONE: ;
			default: ;
		endcase
	end
endmodule

// File: hw/rtl/escape_time_fractal_pixel_top.sv
// Escape-time fractal pixel engine. Pulse start while busy is low with a pixel
// (pixel_x, pixel_y); the word comes back on iterations/red/green/blue for one
// cycle under done, and the receiver cannot stall it, so capture it then. A
// pixel goes through the mapper (multiply, add, push), leaves the queue, then
// runs the z = z^2 + c loop, each step a multiply, check and sum, and ends with
// a last multiply, check and result state. The mapper takes a new pixel once it
// has pushed the last one, which waits while the two-word queue is full, so it
// can run ahead while the back end iterates. WINDOW_SIZE must be a power of two.
// Write registers through cfg_we/cfg_index/cfg_data only while idle.
module escape_time_fractal_pixel_top #(
	parameter int WINDOW_SIZE = etf_pkg::WINDOW_SIZE_DEF,
	parameter int FRAC_BITS = etf_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [etf_pkg::PIX_W-1:0] pixel_x,
	input  logic [etf_pkg::PIX_W-1:0] pixel_y,
	input  logic cfg_we,
	input  logic [etf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [etf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic done,
	output logic [etf_pkg::CNT_W-1:0] iterations,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	import etf_pkg::*;

	logic mode_q;
	logic signed [31:0] center_re_q, center_im_q, const_re_q, const_im_q;
	logic [30:0] radius_q;
	logic [CNT_W-1:0] max_iter_q;
	logic q_full, q_push, q_ne, q_pop, busy_front;
	etf_job_t push_job, head_job;

	// register file; out-of-range index drops the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			center_re_q <= -32'sd201326592;
			center_im_q <= '0;
			radius_q <= 31'd335544320;
			const_re_q <= '0;
			const_im_q <= '0;
			max_iter_q <= 16'd210;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_CENTER_RE: center_re_q <= cfg_data;
				REG_CENTER_IM: center_im_q <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[30:0];
				REG_CONST_RE: const_re_q <= cfg_data;
				REG_CONST_IM: const_im_q <= cfg_data;
				REG_MAX_ITER: max_iter_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// front stalls only its own state machine
	assign busy = busy_front;

	etf_front #(.WINDOW_SIZE(WINDOW_SIZE)) u_front (
		.clk, .arst_n, .start, .pixel_x, .pixel_y,
		.mode(mode_q), .view_center_re(center_re_q), .view_center_im(center_im_q),
		.view_radius(radius_q), .const_re(const_re_q), .const_im(const_im_q),
		.q_full, .q_push, .q_job(push_job), .busy_front
	);

	etf_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_job, .pop(q_pop),
		.full(q_full), .not_empty(q_ne), .head(head_job)
	);

	etf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .job_valid(q_ne), .job(head_job), .max_iter(max_iter_q),
		.job_pop(q_pop), .done, .iterations, .red, .green, .blue
	);
endmodule

// File: hw/rtl/etf_checker.sv
module etf_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [15:0] iterations,
	input logic [7:0] red,
	input logic [7:0] blue
);
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy did not rise after accept");
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && iterations == 16'd0 |-> red == 8'd0 && blue == 8'd0)
		else $error("color not black for zero count");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_blue: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> blue == 8'(iterations * 7)) else $error("blue mismatch");
endmodule

bind escape_time_fractal_pixel_top etf_checker u_etf_checker (
	.clk, .arst_n, .start, .busy, .done, .iterations, .red, .blue
);
